### src/btn_rpt_pkg.sv
// Shared types and constants for the button edge and auto-repeat block.
package btn_rpt_pkg;

    localparam int WORD_W      = 16;
    localparam int CNT_W       = 16;
    localparam int CTL_FIELD_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int ENABLE_REGS = 4;
    localparam int DIV_STEPS   = CNT_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_FAST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_3 = 3'd5;

    localparam logic [CNT_W-1:0] DELAY_RESET  = 16'h0014;
    localparam logic [CNT_W-1:0] PERIOD_RESET = 16'h0004;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic calc_poll;
        logic calc_fast;
        logic step;
        logic out_load;
    } seq_ctl_t;

endpackage

### src/btn_rpt_lane.sv
// One button lane: per-controller hold counters and a bit-serial remainder unit.
module btn_rpt_lane #(
    parameter int CONTROLLERS = 4,
    localparam int IDX_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  btn_rpt_pkg::seq_ctl_t       ctl,
    input  logic [IDX_W-1:0]            idx,
    input  logic                        present,
    input  logic                        enabled,
    input  logic                        held,
    input  logic                        pick,
    input  logic [btn_rpt_pkg::CNT_W-1:0] delay,
    input  logic [btn_rpt_pkg::CNT_W-1:0] period,
    input  logic [btn_rpt_pkg::CNT_W-1:0] preload_val,
    output logic                        fire
);
    import btn_rpt_pkg::*;

    logic [CNT_W-1:0] count_reg [CONTROLLERS];
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] inc;

    logic             active_reg;
    logic             one_reg;
    logic             ge_reg;
    logic [CNT_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;

    assign cur   = count_reg[idx];
    assign inc   = cur + 1'b1;
    assign trial = {rem_reg, quo_reg[CNT_W-1]};
    assign diff  = trial - {1'b0, period};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CONTROLLERS; c++) begin
                count_reg[c] <= '0;
            end
        end else if (ctl.calc_poll && present && enabled) begin
            count_reg[idx] <= held ? inc : '0;
        end else if (ctl.calc_fast && present && pick) begin
            count_reg[idx] <= preload_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (ctl.calc_poll) begin
            active_reg <= present && enabled && held;
        end
    end

    // The remainder of (count - delay) by the period is built one bit a step.
    always_ff @(posedge aclk) begin
        if (ctl.calc_poll) begin
            one_reg <= (inc == CNT_W'(1));
            ge_reg  <= (inc >= delay);
            quo_reg <= inc - delay;
            rem_reg <= '0;
        end else if (ctl.step) begin
            quo_reg <= {quo_reg[CNT_W-2:0], 1'b0};
            if (trial >= {1'b0, period}) begin
                rem_reg <= diff[CNT_W-1:0];
            end else begin
                rem_reg <= trial[CNT_W-1:0];
            end
        end
    end

    assign fire = active_reg && (one_reg || (ge_reg && (rem_reg == '0)));

endmodule

### src/btn_rpt_ctrl.sv
// Sequencer: lookup for every item, remainder steps and result load for a poll.
module btn_rpt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  fast,
    input  logic                  out_free,
    output logic                  busy,
    output btn_rpt_pkg::seq_ctl_t ctl
);
    import btn_rpt_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                step_next  = '0;
                state_next = (fast == CMD_FAST) ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = 1'b1;
        ctl.calc_poll = 1'b0;
        ctl.calc_fast = 1'b0;
        ctl.step      = 1'b0;
        ctl.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_CALC: begin
                ctl.calc_poll = (fast == CMD_POLL);
                ctl.calc_fast = (fast == CMD_FAST);
            end
            ST_DIV:  ctl.step = 1'b1;
            ST_DONE: ctl.out_load = out_free;
            default: busy = 1'b1;
        endcase
    end

endmodule

### src/button_edge_and_auto_repeat.sv
// A poll steps through lookup, the 16 one-bit remainder steps that every lane
// runs on its hold count, and the result load, which waits for a free output.
// No new item is taken until the last is through; a fast-set item loads no result.
// The output register holds a result while the next item is taken in.
// Reset (aresetn, synchronous, active low) clears all hold counters, the
// previous button words and the configuration registers to their defaults.
module button_edge_and_auto_repeat #(
    parameter int CONTROLLERS = 4,
    parameter int BUTTONS     = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [btn_rpt_pkg::CTL_FIELD_W-1:0] s_controller,
    input  logic [btn_rpt_pkg::WORD_W-1:0]      s_button_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [btn_rpt_pkg::WORD_W-1:0]      m_held_buttons,
    output logic [btn_rpt_pkg::WORD_W-1:0]      m_pressed_buttons,
    output logic [btn_rpt_pkg::WORD_W-1:0]      m_repeat_buttons,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btn_rpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btn_rpt_pkg::CNT_W-1:0]       cfg_data
);
    import btn_rpt_pkg::*;

    localparam int IDX_W = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;

    logic [CNT_W-1:0]  delay_reg;
    logic [CNT_W-1:0]  period_reg;
    logic [WORD_W-1:0] enable_reg [ENABLE_REGS];

    logic                   cmd_reg;
    logic [CTL_FIELD_W-1:0] ctl_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [WORD_W-1:0]      pressed_reg;
    logic [WORD_W-1:0]      prev_reg [CONTROLLERS];

    logic              m_valid_reg;
    logic [WORD_W-1:0] held_out_reg;
    logic [WORD_W-1:0] pressed_out_reg;
    logic [WORD_W-1:0] repeat_out_reg;

    logic              accept;
    logic              busy;
    logic              out_free;
    seq_ctl_t          ctl;
    logic [IDX_W-1:0]  idx;
    logic              present;
    logic [WORD_W-1:0] enable_word;
    logic [WORD_W-1:0] low_bit;
    logic [CNT_W-1:0]  period_eff;
    logic [CNT_W-1:0]  preload_val;
    logic [BUTTONS-1:0] lane_fire;
    logic [WORD_W-1:0] repeat_merged;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= DELAY_RESET;
            period_reg <= PERIOD_RESET;
            for (int e = 0; e < ENABLE_REGS; e++) begin
                enable_reg[e] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DELAY:    delay_reg     <= cfg_data;
                REG_PERIOD:   period_reg    <= cfg_data;
                REG_ENABLE_0: enable_reg[0] <= cfg_data;
                REG_ENABLE_1: enable_reg[1] <= cfg_data;
                REG_ENABLE_2: enable_reg[2] <= cfg_data;
                REG_ENABLE_3: enable_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_command;
            ctl_reg  <= s_controller;
            word_reg <= s_button_word;
        end
    end

    assign idx         = IDX_W'(ctl_reg);
    assign present     = (32'(ctl_reg) < CONTROLLERS);
    assign enable_word = enable_reg[ctl_reg];
    assign low_bit     = word_reg & (~word_reg + 1'b1);
    assign period_eff  = (period_reg == '0) ? CNT_W'(1) : period_reg;
    // The preload uses the period as written, so a zero period gives delay - 1.
    assign preload_val = delay_reg + period_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CONTROLLERS; c++) begin
                prev_reg[c] <= '0;
            end
        end else if (ctl.calc_poll && present) begin
            prev_reg[idx] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.calc_poll) begin
            pressed_reg <= present ? (word_reg & ~prev_reg[idx]) : '0;
        end
    end

    btn_rpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .fast     (cmd_reg),
        .out_free (out_free),
        .busy     (busy),
        .ctl      (ctl)
    );

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        localparam int BIT = WORD_W - 1 - b;
        btn_rpt_lane #(
            .CONTROLLERS (CONTROLLERS)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .idx         (idx),
            .present     (present),
            .enabled     (enable_word[BIT]),
            .held        (word_reg[BIT]),
            .pick        (low_bit[BIT]),
            .delay       (delay_reg),
            .period      (period_eff),
            .preload_val (preload_val),
            .fire        (lane_fire[b])
        );
    end

    // Lane 0 reports on the top bit of the word.
    always_comb begin
        repeat_merged = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            repeat_merged[WORD_W-1-b] = lane_fire[b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            held_out_reg    <= word_reg;
            pressed_out_reg <= pressed_reg;
            repeat_out_reg  <= repeat_merged;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_held_buttons    = held_out_reg;
    assign m_pressed_buttons = pressed_out_reg;
    assign m_repeat_buttons  = repeat_out_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("Block took an item while the previous one was in flight.");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> out_free)
        else $error("Result loaded over an item that was not yet taken.");

    a_absent_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.out_load && !present) |-> (repeat_merged == '0))
        else $error("Repeat bits reported for a controller that does not exist.");

    a_no_duplicate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !ctl.out_load) |=> !m_valid)
        else $error("Result item presented again after it was taken.");

endmodule
